[hdl/swmf_pkg.sv]
// swmf_pkg: shared types and constants of the sliding window max filter
// no dependencies; used by swmf_ctrl and sliding_window_max_filter_top
package swmf_pkg;

    localparam int WIN_LEN_W = 7;
    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd3;

    // per-transfer control from the controller to the cell row
    typedef struct packed {
        logic shift;   // input transfer: every cell takes its next value
        logic emit;    // this transfer yields a result
    } swmf_ctl_t;

endpackage

[hdl/swmf_cell.sv]
// swmf_cell: one cell of the running-maximum chain
// no dependencies; instantiated as a row by sliding_window_max_filter_top
module swmf_cell #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           shift,
    input  logic signed [SAMPLE_WIDTH-1:0] x,
    input  logic signed [SAMPLE_WIDTH-1:0] prev,
    output logic signed [SAMPLE_WIDTH-1:0] m,
    output logic signed [SAMPLE_WIDTH-1:0] m_next
);

    logic signed [SAMPLE_WIDTH-1:0] m_reg;

    // max of the new sample and the neighbour's window one shorter
    assign m_next = (x >= prev) ? x : prev;
    assign m      = m_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            m_reg <= m_next;
        end
    end

endmodule

[hdl/swmf_ctrl.sv]
// swmf_ctrl: window length register, fill counter and transfer handshake
// depends on swmf_pkg
module swmf_ctrl #(
    parameter int WINDOW_MAX = 64,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1),
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [swmf_pkg::WIN_LEN_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    input  logic                           first,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output swmf_pkg::swmf_ctl_t            ctl,
    output logic [IDX_W-1:0]               sel
);

    logic [swmf_pkg::WIN_LEN_W-1:0] window_len_reg;
    logic [swmf_pkg::WIN_LEN_W-1:0] window_len_next;
    logic [LEN_W-1:0]               fill_reg;
    logic [LEN_W-1:0]               fill_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [LEN_W-1:0]               eff_len;
    logic [LEN_W-1:0]               fill_base;
    logic [LEN_W-1:0]               fill_inc;
    logic                           accept;

    // zero means one, anything above the row length means the whole row
    always_comb
    begin
        priority if (window_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(window_len_reg) > WINDOW_MAX)
        begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = LEN_W'(window_len_reg);
        end
    end

    assign sel      = IDX_W'(eff_len - LEN_W'(1));
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign fill_base = first ? '0 : fill_reg;
    assign fill_inc  = (fill_base == LEN_W'(WINDOW_MAX)) ? fill_base
                                                         : fill_base + LEN_W'(1);

    assign ctl.shift = accept;
    assign ctl.emit  = accept && (fill_inc >= eff_len);

    always_comb
    begin
        window_len_next = window_len_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        if (cfg_wr_en)
        begin
            window_len_next = cfg_wr_data;
            fill_next       = '0;
        end
        else if (accept)
        begin
            fill_next = fill_inc;
        end
        if (accept)
        begin
            out_valid_next = ctl.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= swmf_pkg::WIN_LEN_RESET;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            window_len_reg <= window_len_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_emit_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> ctl.shift)
        else $error("result raised without an input transfer");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= WINDOW_MAX)
        else $error("fill count beyond row length");

    a_cfg_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> fill_reg == '0)
        else $error("window not cleared by register write");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg)
        else $error("input stalled with empty output register");
`endif

endmodule

[hdl/sliding_window_max_filter_top.sv]
// sliding_window_max_filter_top: running maximum over the last window_len samples
// depends on swmf_pkg, swmf_cell and swmf_ctrl
//
// One sample is taken per clock unless input stalls. A row of WINDOW_MAX cells
// holds, in cell i, the maximum of the last i+1 samples; each transfer every cell
// takes the larger of the new sample and its left neighbour, so the whole row
// updates on each transfer and the result is the next value of cell window_len-1,
// registered by the input transfer. Input stalls only while that output register
// holds a result not yet taken. The first flag or a write to window_len restarts
// the count; the first window_len-1 samples of a sequence give no result.
module sliding_window_max_filter_top #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [swmf_pkg::WIN_LEN_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           first,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] window_max
);

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    swmf_pkg::swmf_ctl_t            ctl;
    logic [IDX_W-1:0]               sel;
    logic signed [SAMPLE_WIDTH-1:0] cell_m    [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] cell_next [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] window_max_reg;

    swmf_ctrl #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .first       (first),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ctl         (ctl),
        .sel         (sel)
    );

    // cell 0 sees the sample on both sides, so it simply stores it
    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swmf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk    (clk),
            .shift  (ctl.shift),
            .x      (sample),
            .prev   ((i == 0) ? sample : cell_m[(i == 0) ? 0 : i - 1]),
            .m      (cell_m[i]),
            .m_next (cell_next[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            window_max_reg <= cell_next[sel];
        end
    end

    assign window_max = window_max_reg;

endmodule
